// ----- hdl/lsf_pkg.sv -----
package lsf_pkg;

  localparam int PatternMaxDef = 16;
  localparam int LineColsDef   = 80;
  localparam int PatBytes      = 16;
  localparam int CfgIdxW       = 3;
  localparam int CfgDataW      = 64;
  localparam int PatLenW       = 5;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PATTERN_LOW    = 3'd0,
    REG_PATTERN_HIGH   = 3'd1,
    REG_PATTERN_LENGTH = 3'd2,
    REG_FOLD_CASE      = 3'd3,
    REG_INVERT         = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_BYTE    = 2'd0,
    MODE_NEWLINE = 2'd1,
    MODE_EOF     = 2'd2
  } mode_e;

  typedef struct packed {
    logic [63:0]        pattern_low;
    logic [63:0]        pattern_high;
    logic [PatLenW-1:0] pattern_length;
    logic               fold_case;
    logic               invert;
  } cfg_t;

  // ASCII only: a-z to A-Z, everything else unchanged
  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
    logic [7:0] r;
    r = c;
    if (en && c >= 8'h61 && c <= 8'h7a) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

endpackage

// ----- hdl/lsf_cfg.sv -----
module lsf_cfg
  import lsf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_PATTERN_LOW:    cfg_d.pattern_low    = cfg_data_i;
        REG_PATTERN_HIGH:   cfg_d.pattern_high   = cfg_data_i;
        REG_PATTERN_LENGTH: cfg_d.pattern_length = cfg_data_i[PatLenW-1:0];
        REG_FOLD_CASE:      cfg_d.fold_case      = cfg_data_i[0];
        REG_INVERT:         cfg_d.invert         = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hdl/lsf_match.sv -----
module lsf_match
  import lsf_pkg::*;
#(
  parameter int PATTERN_MAX = PatternMaxDef,
  parameter int LEN_W       = 7,
  parameter int WIN_DEPTH   = 15
) (
  input  cfg_t                      cfg_i,
  input  logic [7:0]                ch_i,
  input  logic [WIN_DEPTH-1:0][7:0] window_i,
  input  logic [LEN_W-1:0]          line_len_i,
  output logic                      hit_o
);

  logic [PatLenW-1:0]         pat_len;
  logic [PatBytes-1:0][7:0]   pat;
  logic [PATTERN_MAX-1:0]     lane_ok;
  logic                       len_ok;

  assign pat_len = (cfg_i.pattern_length > PatLenW'(PATTERN_MAX)) ?
                   PatLenW'(PATTERN_MAX) : cfg_i.pattern_length;
  assign pat     = {cfg_i.pattern_high, cfg_i.pattern_low};

  // lane 0 is the incoming byte, lane i the byte i places back;
  // the pattern is aligned so that its last byte meets lane 0
  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_lane
    logic [7:0] lane_byte;
    logic [3:0] pat_idx;
    logic       active;
    if (i == 0) begin : g_head
      assign lane_byte = ch_i;
    end else begin : g_tail
      assign lane_byte = window_i[i-1];
    end
    assign pat_idx    = 4'(pat_len - PatLenW'(i) - PatLenW'(1));
    assign active     = PatLenW'(i) < pat_len;
    assign lane_ok[i] = !active ||
                        (fold_byte(lane_byte, cfg_i.fold_case) ==
                         fold_byte(pat[pat_idx], cfg_i.fold_case));
  end

  assign len_ok = (8'(line_len_i) + 8'd1) >= 8'(pat_len);
  assign hit_o  = (pat_len != '0) && len_ok && (&lane_ok);

endmodule

// ----- hdl/lsf_line_ctrl.sv -----
module lsf_line_ctrl
  import lsf_pkg::*;
#(
  parameter int LINE_COLS   = LineColsDef,
  parameter int LEN_W       = 7,
  parameter int WIN_DEPTH   = 15
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      fire_i,
  input  mode_e                     mode_i,
  input  logic [7:0]                ch_i,
  input  cfg_t                      cfg_i,
  input  logic                      hit_i,
  output logic [WIN_DEPTH-1:0][7:0] window_o,
  output logic [LEN_W-1:0]          line_len_o,
  output logic                      out_ready_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      status_o,
  output logic                      selected_o,
  output logic [31:0]               line_count_o
);

  logic [WIN_DEPTH-1:0][7:0] window_q, window_d;
  logic [LEN_W-1:0]          len_q, len_d;
  logic                      found_q, found_d;
  logic                      halted_q, halted_d;
  logic [31:0]               total_q, total_d;
  logic                      out_valid_q, out_valid_d;
  logic                      status_q, selected_q;
  logic [31:0]               count_q;
  logic                      emit, e_status, e_sel, sel;

  assign out_ready_o = !out_valid_q || !out_stall_i;

  always_comb begin
    window_d = window_q;
    len_d    = len_q;
    found_d  = found_q;
    halted_d = halted_q;
    total_d  = total_q;
    emit     = 1'b0;
    e_status = 1'b0;
    e_sel    = 1'b0;
    sel      = found_q ^ cfg_i.invert;
    if (fire_i) begin
      case (mode_i)
        MODE_EOF: begin
          emit     = !halted_q && (len_q != '0);
          e_status = 1'b1;
          window_d = '0;
          len_d    = '0;
          found_d  = 1'b0;
          halted_d = 1'b0;
        end
        MODE_BYTE: begin
          if (!halted_q) begin
            if (ch_i == 8'h00 || len_q >= LEN_W'(LINE_COLS - 2)) begin
              // drop the rest of the input until end of file
              emit     = 1'b1;
              e_status = 1'b1;
              window_d = '0;
              len_d    = '0;
              found_d  = 1'b0;
              halted_d = 1'b1;
            end else begin
              found_d     = found_q | hit_i;
              window_d[0] = ch_i;
              for (int k = 1; k < WIN_DEPTH; k++) begin
                window_d[k] = window_q[k-1];
              end
              len_d = len_q + LEN_W'(1);
            end
          end
        end
        MODE_NEWLINE: begin
          if (!halted_q) begin
            if (sel && total_q != '1) begin
              total_d = total_q + 32'd1;
            end
            emit     = 1'b1;
            e_status = 1'b0;
            e_sel    = sel;
            window_d = '0;
            len_d    = '0;
            found_d  = 1'b0;
          end
        end
        default: ;
      endcase
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q    <= '0;
      len_q       <= '0;
      found_q     <= 1'b0;
      halted_q    <= 1'b0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      window_q    <= window_d;
      len_q       <= len_d;
      found_q     <= found_d;
      halted_q    <= halted_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      status_q   <= e_status;
      selected_q <= e_sel;
      count_q    <= total_d;
    end
  end

  assign window_o     = window_q;
  assign line_len_o   = len_q;
  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign selected_o   = selected_q;
  assign line_count_o = count_q;

  a_err_not_selected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q |-> !selected_q)
    else $error("error word carries a selected flag");

  a_total_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q >= $past(total_q))
    else $error("selected line total went backwards");

  a_halted_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> (len_q == '0) && !found_q)
    else $error("line state not cleared while halted");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !emit)
    else $error("result register overwritten while stalled");

endmodule

// ----- hdl/line_substring_filter.sv -----
// Line filter for a byte stream: each text word carries one byte, a newline
// word ends the line and an end-of-file word closes the stream. A line is
// selected when it contains the programmed pattern (up to PATTERN_MAX bytes,
// optional ASCII case folding), inverted when the invert register is set.
// Each newline gives one result word with the selected flag and a saturating
// count of selected lines; an overlong line, a zero byte or a last line
// without newline gives an error word, after which input is dropped until
// end of file. One word is taken every clock cycle while the result side
// does not stall; a waiting result word holds the input. A result word is
// presented once its word has passed the input register and the result
// register. The whole pattern window is compared combinationally, which
// sets the clock path of the design. Program the registers while idle.
module line_substring_filter
  import lsf_pkg::*;
#(
  parameter int PATTERN_MAX = PatternMaxDef,
  parameter int LINE_COLS   = LineColsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          mode_i,
  input  logic [7:0]          ch_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                status_o,
  output logic                selected_o,
  output logic [31:0]         line_count_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int LenW     = $clog2(LINE_COLS - 1);
  localparam int WinDepth = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;

  cfg_t                     cfg;
  logic                     s1_valid_q, s1_valid_d;
  logic [1:0]               s1_mode_q;
  logic [7:0]               s1_ch_q;
  logic                     accept, fire, out_ready, hit;
  logic [WinDepth-1:0][7:0] window;
  logic [LenW-1:0]          line_len;

  assign fire       = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (fire) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_mode_q <= mode_i;
      s1_ch_q   <= ch_i;
    end
  end

  lsf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lsf_match #(
    .PATTERN_MAX (PATTERN_MAX),
    .LEN_W       (LenW),
    .WIN_DEPTH   (WinDepth)
  ) u_match (
    .cfg_i      (cfg),
    .ch_i       (s1_ch_q),
    .window_i   (window),
    .line_len_i (line_len),
    .hit_o      (hit)
  );

  lsf_line_ctrl #(
    .LINE_COLS   (LINE_COLS),
    .LEN_W       (LenW),
    .WIN_DEPTH   (WinDepth)
  ) u_line_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .mode_i       (mode_e'(s1_mode_q)),
    .ch_i         (s1_ch_q),
    .cfg_i        (cfg),
    .hit_i        (hit),
    .window_o     (window),
    .line_len_o   (line_len),
    .out_ready_o  (out_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .selected_o   (selected_o),
    .line_count_o (line_count_o)
  );

endmodule

// ----- tb/tb.sv -----
module tb;
  import lsf_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int RandWords = 1300;
  localparam int Latency = 2;
  localparam int LastCol = LineColsDef - 2;
  localparam int HoldCycles = 300;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic        status;
    logic        selected;
    logic [31:0] count;
  } result_t;

  typedef enum logic [1:0] {
    ROW_WORD,
    ROW_RUN,
    ROW_PROG
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  mode;
    logic [7:0]  ch;
    logic [6:0]  reps;
    cfg_t        cfg;
    logic        typed;
    result_t     want;
  } row_t;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [1:0]          mode_i = MODE_BYTE;
  logic [7:0]          ch_i = 8'h00;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                status_o;
  logic                selected_o;
  logic [31:0]         line_count_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = REG_PATTERN_LOW;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  line_substring_filter #(
    .PATTERN_MAX(PatternMaxDef),
    .LINE_COLS  (LineColsDef)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .ch_i        (ch_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .selected_o  (selected_o),
    .line_count_o(line_count_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  result_t     line_results_q[$];
  row_t        dir_rows[$];
  int          fail_cnt = 0;
  int          send_idle_pct = 14;
  int          recv_idle_pct = 53;
  int          hold_req = 0;
  int          hold_left = 0;
  int          live_words = 0;
  int unsigned cyc = 0;

  // filter state as the block should hold it
  logic [7:0]  seen_bytes[PatternMaxDef-1];
  logic [6:0]  cur_len;
  logic        hit_in_line;
  logic        stopped;
  logic [31:0] sel_total;
  cfg_t        cfg_now;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    while (cyc < CycleLimit) begin
      @(posedge clk_i);
      cyc++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [7:0] upcase(input logic [7:0] c);
    if (cfg_now.fold_case && c >= 8'h61 && c <= 8'h7a) begin
      return c - 8'h20;
    end
    return c;
  endfunction

  function automatic logic [7:0] pat_at(input int k);
    if (k < 8) begin
      return cfg_now.pattern_low[8*k +: 8];
    end
    return cfg_now.pattern_high[8*(k-8) +: 8];
  endfunction

  function automatic int pat_len();
    if (int'(cfg_now.pattern_length) > PatternMaxDef) begin
      return PatternMaxDef;
    end
    return int'(cfg_now.pattern_length);
  endfunction

  // does the pattern end at byte c, with the window holding what precedes it
  function automatic logic pattern_ends(input logic [7:0] c);
    int n;
    int i;
    logic [7:0] b;
    n = pat_len();
    if (n == 0 || int'(cur_len) + 1 < n) begin
      return 1'b0;
    end
    for (i = 0; i < n; i++) begin
      b = (i == 0) ? c : seen_bytes[i-1];
      if (upcase(b) != upcase(pat_at(n - 1 - i))) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic clear_line();
    int k;
    for (k = 0; k < PatternMaxDef - 1; k++) begin
      seen_bytes[k] = 8'h00;
    end
    cur_len = '0;
    hit_in_line = 1'b0;
  endtask

  task automatic step_filter(input logic [1:0] m, input logic [7:0] c,
                             output logic has, output result_t r);
    logic sel;
    int k;
    has = 1'b0;
    r = '0;
    if (m == MODE_EOF) begin
      has = !stopped && cur_len != '0;
      clear_line();
      stopped = 1'b0;
      r = {1'b1, 1'b0, sel_total};
    end else if (!stopped && m == MODE_BYTE) begin
      if (c == 8'h00 || int'(cur_len) >= LastCol) begin
        clear_line();
        stopped = 1'b1;
        has = 1'b1;
        r = {1'b1, 1'b0, sel_total};
      end else begin
        if (pattern_ends(c)) begin
          hit_in_line = 1'b1;
        end
        for (k = PatternMaxDef - 2; k > 0; k--) begin
          seen_bytes[k] = seen_bytes[k-1];
        end
        seen_bytes[0] = c;
        cur_len = cur_len + 7'd1;
      end
    end else if (!stopped && m == MODE_NEWLINE) begin
      sel = hit_in_line ^ cfg_now.invert;
      if (sel && sel_total != '1) begin
        sel_total = sel_total + 32'd1;
      end
      clear_line();
      has = 1'b1;
      r = {1'b0, sel, sel_total};
    end
  endtask

  function automatic logic [7:0] rand_text();
    if ($urandom_range(99) < 70) begin
      case ($urandom_range(3))
        0: return "a";
        1: return "b";
        2: return "A";
        default: return "B";
      endcase
    end
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic cfg_t rand_cfg();
    cfg_t c;
    int r;
    int n;
    int k;
    c = '0;
    r = $urandom_range(99);
    if (r < 8) begin
      n = 0;
    end else if (r < 16) begin
      n = PatternMaxDef;
    end else if (r < 21) begin
      n = $urandom_range(PatternMaxDef + 1, 31);
    end else begin
      n = $urandom_range(1, 6);
    end
    for (k = 0; k < 8; k++) begin
      c.pattern_low[8*k +: 8] = rand_text();
      c.pattern_high[8*k +: 8] = rand_text();
    end
    // a zero byte in the pattern can never be matched
    if ($urandom_range(19) == 0) begin
      k = $urandom_range(7);
      c.pattern_low[8*k +: 8] = 8'h00;
    end
    c.pattern_length = 5'(n);
    c.fold_case = 1'($urandom_range(1));
    c.invert = 1'($urandom_range(1));
    return c;
  endfunction

  function automatic row_t mk_word(input logic [1:0] m, input logic [7:0] c);
    row_t w;
    w = '0;
    w.kind = ROW_WORD;
    w.mode = m;
    w.ch = c;
    return w;
  endfunction

  function automatic row_t mk_check(input logic [1:0] m, input logic [7:0] c,
                                    input logic st, input logic sel,
                                    input logic [31:0] cnt);
    row_t w;
    w = mk_word(m, c);
    w.typed = 1'b1;
    w.want = {st, sel, cnt};
    return w;
  endfunction

  function automatic row_t mk_run(input logic [7:0] c, input int n);
    row_t w;
    w = mk_word(MODE_BYTE, c);
    w.kind = ROW_RUN;
    w.reps = 7'(n);
    return w;
  endfunction

  function automatic row_t mk_prog(input logic [63:0] lo, input logic [63:0] hi,
                                   input logic [4:0] len, input logic fold,
                                   input logic inv);
    row_t w;
    w = '0;
    w.kind = ROW_PROG;
    w.cfg.pattern_low = lo;
    w.cfg.pattern_high = hi;
    w.cfg.pattern_length = len;
    w.cfg.fold_case = fold;
    w.cfg.invert = inv;
    return w;
  endfunction

  task automatic offer(input logic [1:0] m, input logic [7:0] c, input logic typed,
                       input result_t texp);
    logic has;
    result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    if (!stopped || m == MODE_EOF) begin
      live_words++;
    end
    step_filter(m, c, has, r);
    if (has) begin
      line_results_q.push_back(typed ? texp : r);
    end
    in_valid_i <= 1'b1;
    mode_i <= m;
    ch_i <= c;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send(input logic [1:0] m, input logic [7:0] c);
    offer(m, c, 1'b0, '0);
  endtask

  task automatic send_text(input int n);
    repeat (n) send(MODE_BYTE, rand_text());
  endtask

  task automatic send_pattern();
    int k;
    logic [7:0] b;
    for (k = 0; k < pat_len(); k++) begin
      b = pat_at(k);
      if (cfg_now.fold_case && $urandom_range(1) == 1 &&
          ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z"))) begin
        b = b ^ 8'h20;
      end
      send(MODE_BYTE, b);
    end
  endtask

  // drop valid, wait for every pending line result, then let the pipe empty
  task automatic settle();
    in_valid_i <= 1'b0;
    while (line_results_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [63:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic load_cfg(input cfg_t c);
    write_reg(REG_PATTERN_LOW, c.pattern_low);
    write_reg(REG_PATTERN_HIGH, c.pattern_high);
    write_reg(REG_PATTERN_LENGTH, {59'd0, c.pattern_length});
    write_reg(REG_FOLD_CASE, {63'd0, c.fold_case});
    write_reg(REG_INVERT, {63'd0, c.invert});
    cfg_valid_i <= 1'b0;
    cfg_now = c;
  endtask

  task automatic make_line();
    int r;
    int pre;
    r = $urandom_range(99);
    if (r < 4) begin
      repeat ($urandom_range(1, 4)) send(2'($urandom_range(3)), 8'($urandom_range(255)));
      if (stopped) begin
        send(MODE_EOF, 8'($urandom_range(255)));
      end
    end else if (r < 7) begin
      // overlong line, then close the file
      send_text(LineColsDef - 1);
      send(MODE_NEWLINE, 8'($urandom_range(255)));
      send(MODE_EOF, 8'($urandom_range(255)));
    end else if (r < 10) begin
      send_text($urandom_range(1, 6));
      send(MODE_EOF, 8'($urandom_range(255)));
    end else if (r < 13) begin
      send_text($urandom_range(0, 5));
      send(MODE_BYTE, 8'h00);
      send_text($urandom_range(0, 3));
      send(MODE_NEWLINE, 8'($urandom_range(255)));
      send(MODE_EOF, 8'($urandom_range(255)));
    end else begin
      pre = ($urandom_range(19) == 0) ? $urandom_range(40, 60) : $urandom_range(0, 8);
      send_text(pre);
      if ($urandom_range(1) == 1) begin
        send_pattern();
      end
      send_text(pre > 8 ? $urandom_range(0, 2) : $urandom_range(0, 4));
      send(MODE_NEWLINE, 8'($urandom_range(255)));
      if ($urandom_range(19) == 0) begin
        send(MODE_EOF, 8'($urandom_range(255)));
      end
    end
  endtask

  task automatic check_word();
    result_t got;
    result_t want;
    got = {status_o, selected_o, line_count_o};
    if (line_results_q.size() == 0) begin
      fail_cnt++;
      if (fail_cnt <= 10) begin
        $display("unexpected result word: status %0d selected %0d count %0d",
                 got.status, got.selected, got.count);
      end
    end else begin
      want = line_results_q.pop_front();
      if (got.status !== want.status || got.selected !== want.selected ||
          got.count !== want.count) begin
        fail_cnt++;
        if (fail_cnt <= 10) begin
          $display("result word differs: status %0d/%0d selected %0d/%0d count %0d/%0d",
                   want.status, got.status, want.selected, got.selected,
                   want.count, got.count);
        end
      end
    end
  endtask

  // receiver: check accepted words, stall at random or for a requested hold-off
  initial begin
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        check_word();
      end
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  initial begin
    int i;
    int start;
    int phase;
    int progress;
    clear_line();
    stopped = 1'b0;
    sel_total = '0;
    cfg_now = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset state: empty pattern never matches
    dir_rows.push_back(mk_word(MODE_BYTE, "x"));
    dir_rows.push_back(mk_check(MODE_NEWLINE, 8'h00, 1'b0, 1'b0, 32'd0));
    dir_rows.push_back(mk_check(MODE_NEWLINE, 8'hff, 1'b0, 1'b0, 32'd0));
    dir_rows.push_back(mk_check(MODE_BYTE, 8'h00, 1'b1, 1'b0, 32'd0));
    dir_rows.push_back(mk_word(MODE_BYTE, "a"));
    dir_rows.push_back(mk_word(MODE_NEWLINE, 8'h00));
    dir_rows.push_back(mk_word(MODE_EOF, 8'h00));
    dir_rows.push_back(mk_word(MODE_BYTE, 8'hff));
    dir_rows.push_back(mk_check(MODE_EOF, 8'h00, 1'b1, 1'b0, 32'd0));
    dir_rows.push_back(mk_word(MODE_UNUSED, 8'h55));
    dir_rows.push_back(mk_word(MODE_EOF, 8'haa));
    // "hello" folded, then invert set mid-line: the match already seen holds
    dir_rows.push_back(mk_prog(64'h0000_006f_6c6c_6568, '0, 5'd5, 1'b1, 1'b0));
    dir_rows.push_back(mk_word(MODE_BYTE, "H"));
    dir_rows.push_back(mk_word(MODE_BYTE, "e"));
    dir_rows.push_back(mk_word(MODE_BYTE, "L"));
    dir_rows.push_back(mk_word(MODE_BYTE, "l"));
    dir_rows.push_back(mk_word(MODE_BYTE, "O"));
    dir_rows.push_back(mk_prog(64'h0000_006f_6c6c_6568, '0, 5'd5, 1'b1, 1'b1));
    dir_rows.push_back(mk_word(MODE_NEWLINE, 8'h00));
    dir_rows.push_back(mk_word(MODE_NEWLINE, 8'h00));
    // full-width pattern, length beyond the maximum
    dir_rows.push_back(mk_prog('1, '1, 5'd31, 1'b0, 1'b0));
    dir_rows.push_back(mk_run(8'hff, PatternMaxDef));
    dir_rows.push_back(mk_word(MODE_NEWLINE, 8'h00));
    // zero byte inside the pattern
    dir_rows.push_back(mk_prog(64'h0000_0000_0000_e100, '0, 5'd2, 1'b1, 1'b0));
    dir_rows.push_back(mk_word(MODE_BYTE, 8'h01));
    dir_rows.push_back(mk_word(MODE_BYTE, 8'hc1));
    dir_rows.push_back(mk_word(MODE_NEWLINE, 8'h00));
    // overlong line
    dir_rows.push_back(mk_run("z", LastCol));
    dir_rows.push_back(mk_word(MODE_BYTE, "z"));
    dir_rows.push_back(mk_word(MODE_NEWLINE, 8'h00));
    dir_rows.push_back(mk_word(MODE_EOF, 8'h00));

    for (i = 0; i < dir_rows.size(); i++) begin
      case (dir_rows[i].kind)
        ROW_PROG: begin
          settle();
          load_cfg(dir_rows[i].cfg);
        end
        ROW_RUN: begin
          repeat (dir_rows[i].reps) send(MODE_BYTE, dir_rows[i].ch);
        end
        default: begin
          offer(dir_rows[i].mode, dir_rows[i].ch, dir_rows[i].typed, dir_rows[i].want);
        end
      endcase
    end

    start = live_words;
    phase = 0;
    while (live_words - start < RandWords) begin
      progress = live_words - start;
      if (progress < RandWords / 3) begin
        send_idle_pct = 14;
        recv_idle_pct = 53;
      end else if (progress < 2 * RandWords / 3) begin
        send_idle_pct = 53;
        recv_idle_pct = 14;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      settle();
      load_cfg(rand_cfg());
      // hold the output off while words keep coming, so the block backs up
      if (phase == 1 || phase == 12) begin
        hold_req = HoldCycles;
      end
      repeat ($urandom_range(4, 16)) make_line();
      phase++;
    end
    settle();

    if (fail_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
